/* sv/rck_pkg.sv */
// shared types and constants for the rolling canonical k-mer block
package rck_pkg;

    localparam int WORD_W = 62;
    localparam int CODE_W = 2;
    localparam int K_W    = 5;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 2;
    localparam int MODE_W = 2;
    localparam int ENC_W  = 2;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_KMER_SIZE       = 2'd0;
    localparam logic [IDX_W-1:0] CFG_OUTPUT_MODE     = 2'd1;
    localparam logic [IDX_W-1:0] CFG_LETTER_ENCODING = 2'd2;

    // output selection
    localparam logic [MODE_W-1:0] MODE_DIRECT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REVCOMP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIN     = 2'd2;

    // letter encodings
    localparam logic [ENC_W-1:0] ENC_ASCII  = 2'd0;
    localparam logic [ENC_W-1:0] ENC_CODE   = 2'd1;
    localparam logic [ENC_W-1:0] ENC_PACKED = 2'd2;

    // packed letter slots
    localparam logic [1:0] SLOT_FIRST = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD = 2'd2;
    localparam logic [1:0] SLOT_LAST  = 2'd3;

    // complement of a 2-bit letter code
    localparam logic [CODE_W-1:0] COMP_MASK = 2'b10;

    localparam logic [K_W-1:0] K_RESET = 5'd31;

    // one letter handed from the input stage to the cell row
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              flush;
        logic              last;
    } t_letter;

    // control broadcast to every cell
    typedef struct packed {
        logic              shift;
        logic              flush;
        logic              clear;
        logic [CODE_W-1:0] code;
        logic [K_W-1:0]    k;
    } t_cell_ctl;

endpackage

/* sv/rck_in_if.sv */
// input channel carrying one symbol byte per transaction
interface rck_in_if;
    logic                       valid;
    logic                       ready;
    logic [rck_pkg::BYTE_W-1:0] symbol_byte;
    logic                       start_sequence;

    modport source(output valid, output symbol_byte, output start_sequence, input ready);
    modport sink(input valid, input symbol_byte, input start_sequence, output ready);
endinterface

/* sv/rck_out_if.sv */
// output channel carrying one k-mer result per transaction
interface rck_out_if;
    logic                       valid;
    logic                       ready;
    logic [rck_pkg::WORD_W-1:0] kmer_value;
    logic                       forward_smaller;
    logic                       last_of_item;

    modport source(output valid, output kmer_value, output forward_smaller,
                   output last_of_item, input ready);
    modport sink(input valid, input kmer_value, input forward_smaller,
                 input last_of_item, output ready);
endinterface

/* sv/rck_letter_src.sv */
// input holding stage that unpacks a symbol byte into one letter per cycle while i_take is high
module rck_letter_src (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rck_in_if.sink                       i_sym,
    input  logic [rck_pkg::ENC_W-1:0]    i_enc,
    input  logic                         i_take,
    output rck_pkg::t_letter             o_letter
);

    logic                       r_valid;
    logic [rck_pkg::BYTE_W-1:0] r_byte;
    logic                       r_start;
    logic [1:0]                 r_slot;
    logic [rck_pkg::CODE_W-1:0] w_code;
    logic                       w_last;
    logic                       w_accept;

    // letter extraction for the current slot
    always_comb begin
        w_code = r_byte[1:0];
        w_last = 1'b1;
        case (i_enc)
            rck_pkg::ENC_ASCII: begin
                w_code = r_byte[2:1];
            end
            rck_pkg::ENC_PACKED: begin
                w_last = (r_slot == rck_pkg::SLOT_LAST);
                case (r_slot)
                    rck_pkg::SLOT_FIRST:  w_code = r_byte[7:6];
                    rck_pkg::SLOT_SECOND: w_code = r_byte[5:4];
                    rck_pkg::SLOT_THIRD:  w_code = r_byte[3:2];
                    default:              w_code = r_byte[1:0];
                endcase
            end
            default: begin
                w_code = r_byte[1:0];
            end
        endcase
    end

    assign o_letter.valid = r_valid;
    assign o_letter.code  = w_code;
    assign o_letter.flush = r_start && (r_slot == rck_pkg::SLOT_FIRST);
    assign o_letter.last  = w_last;

    // free again as the last letter of the held byte leaves
    assign i_sym.ready = !r_valid || (i_take && w_last);
    assign w_accept    = i_sym.valid && i_sym.ready;

    // holding register and slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= rck_pkg::SLOT_FIRST;
        end else if (w_accept) begin
            r_valid <= 1'b1;
            r_slot  <= rck_pkg::SLOT_FIRST;
        end else if (i_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_slot <= r_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte  <= i_sym.symbol_byte;
            r_start <= i_sym.start_sequence;
        end
    end

endmodule

/* sv/rck_cell.sv */
// one letter position of the forward and reverse-complement words
module rck_cell #(
    parameter int Idx = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rck_pkg::t_cell_ctl                i_ctl,
    input  logic [rck_pkg::CODE_W-1:0]        i_fwd_low,
    input  logic [rck_pkg::CODE_W-1:0]        i_rev_high,
    output logic [rck_pkg::CODE_W-1:0]        o_fwd,
    output logic [rck_pkg::CODE_W-1:0]        o_rev,
    output logic [rck_pkg::CODE_W-1:0]        o_fwd_nxt,
    output logic [rck_pkg::CODE_W-1:0]        o_rev_nxt
);

    localparam logic [rck_pkg::K_W-1:0] Pos = rck_pkg::K_W'(Idx);

    logic                       w_fwd_ok;
    logic                       w_active;
    logic                       w_top;
    logic [rck_pkg::CODE_W-1:0] r_fwd;
    logic [rck_pkg::CODE_W-1:0] r_rev;

    assign w_active = (Pos < i_ctl.k);
    assign w_top    = (Pos == (i_ctl.k - rck_pkg::K_W'(1)));
    // the bottom cell takes the new letter, which a flush does not clear
    assign w_fwd_ok = (Idx == 0) || !i_ctl.flush;

    // shifted values: forward moves up, reverse moves down
    always_comb begin
        o_fwd_nxt = (w_active && w_fwd_ok) ? i_fwd_low : '0;
        if (w_top) begin
            o_rev_nxt = i_ctl.code ^ rck_pkg::COMP_MASK;
        end else if (w_active && !i_ctl.flush) begin
            o_rev_nxt = i_rev_high;
        end else begin
            o_rev_nxt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_fwd <= '0;
            r_rev <= '0;
        end else if (i_ctl.shift) begin
            r_fwd <= o_fwd_nxt;
            r_rev <= o_rev_nxt;
        end
    end

    assign o_fwd = r_fwd;
    assign o_rev = r_rev;

endmodule

/* sv/rolling_canonical_kmer.sv */
// top level: rolling forward and reverse-complement k-mer over a row of letter cells
// the input stage holds each byte, and a completed k-mer is registered in the output register
// throughput: one letter per cycle through the cell row while the output is free, so one byte
// per cycle in ascii and code modes; a packed byte carries four letters (up to 4 results)
// the single output register takes one result per cycle; a stall holds the row
// reset (synchronous, active low): words and count cleared, k = 31, minimum mode, ascii
module rolling_canonical_kmer #(
    parameter int MAX_LETTERS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rck_in_if.sink                        i_sym,
    rck_out_if.source                     o_kmer,
    input  logic                          i_cfg_we,
    input  logic [rck_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [rck_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int Cells = MAX_LETTERS - 1;
    localparam logic [rck_pkg::K_W-1:0] KMax = rck_pkg::K_W'(Cells);

    logic [rck_pkg::K_W-1:0]    r_kmer_size;
    logic [rck_pkg::MODE_W-1:0] r_mode;
    logic [rck_pkg::ENC_W-1:0]  r_enc;
    logic [rck_pkg::K_W-1:0]    r_seen;
    logic [rck_pkg::K_W-1:0]    n_seen;
    logic [rck_pkg::K_W-1:0]    w_base;
    logic [rck_pkg::K_W-1:0]    w_k;
    logic                       w_kmer_wr;
    logic                       w_take;
    logic                       w_emit;
    logic                       w_out_free;
    logic                       w_fwd_lt;
    rck_pkg::t_letter           w_let;
    rck_pkg::t_cell_ctl         w_ctl;

    logic [rck_pkg::CODE_W-1:0] w_cfwd     [Cells];
    logic [rck_pkg::CODE_W-1:0] w_crev     [Cells];
    logic [rck_pkg::CODE_W-1:0] w_cfwd_nxt [Cells];
    logic [rck_pkg::CODE_W-1:0] w_crev_nxt [Cells];
    logic [rck_pkg::WORD_W-1:0] w_fwd_nxt;
    logic [rck_pkg::WORD_W-1:0] w_rev_nxt;
    logic [rck_pkg::WORD_W-1:0] w_fwd_cur;
    logic [rck_pkg::WORD_W-1:0] w_sel;

    logic                       r_ov;
    logic [rck_pkg::WORD_W-1:0] r_kmer;
    logic                       r_fs;
    logic                       r_last;

    // configuration registers
    assign w_kmer_wr = i_cfg_we && (i_cfg_index == rck_pkg::CFG_KMER_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_size <= rck_pkg::K_RESET;
            r_mode      <= rck_pkg::MODE_MIN;
            r_enc       <= rck_pkg::ENC_ASCII;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rck_pkg::CFG_KMER_SIZE:       r_kmer_size <= i_cfg_data;
                rck_pkg::CFG_OUTPUT_MODE:     r_mode      <= i_cfg_data[rck_pkg::MODE_W-1:0];
                rck_pkg::CFG_LETTER_ENCODING: r_enc       <= i_cfg_data[rck_pkg::ENC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective k: zero means one, capped at the number of cells
    always_comb begin
        if (r_kmer_size == '0) begin
            w_k = rck_pkg::K_W'(1);
        end else if (r_kmer_size > KMax) begin
            w_k = KMax;
        end else begin
            w_k = r_kmer_size;
        end
    end

    // input stage
    rck_letter_src u_src (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sym    (i_sym),
        .i_enc    (r_enc),
        .i_take   (w_take),
        .o_letter (w_let)
    );

    assign w_out_free = !r_ov || o_kmer.ready;
    assign w_take     = w_let.valid && w_out_free;

    // cell row control
    assign w_ctl.shift = w_take;
    assign w_ctl.flush = w_let.flush;
    assign w_ctl.clear = w_kmer_wr;
    assign w_ctl.code  = w_let.code;
    assign w_ctl.k     = w_k;

    for (genvar g = 0; g < Cells; g++) begin : g_cell
        logic [rck_pkg::CODE_W-1:0] w_low;
        logic [rck_pkg::CODE_W-1:0] w_high;

        if (g == 0) begin : g_bottom
            assign w_low = w_let.code;
        end else begin : g_mid_low
            assign w_low = w_cfwd[g-1];
        end
        if (g == Cells - 1) begin : g_top
            assign w_high = '0;
        end else begin : g_mid_high
            assign w_high = w_crev[g+1];
        end

        rck_cell #(.Idx(g)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_fwd_low  (w_low),
            .i_rev_high (w_high),
            .o_fwd      (w_cfwd[g]),
            .o_rev      (w_crev[g]),
            .o_fwd_nxt  (w_cfwd_nxt[g]),
            .o_rev_nxt  (w_crev_nxt[g])
        );

        assign w_fwd_nxt[2*g+1:2*g] = w_cfwd_nxt[g];
        assign w_rev_nxt[2*g+1:2*g] = w_crev_nxt[g];
        assign w_fwd_cur[2*g+1:2*g] = w_cfwd[g];
    end

    if (2 * Cells < rck_pkg::WORD_W) begin : g_pad
        assign w_fwd_nxt[rck_pkg::WORD_W-1:2*Cells] = '0;
        assign w_rev_nxt[rck_pkg::WORD_W-1:2*Cells] = '0;
        assign w_fwd_cur[rck_pkg::WORD_W-1:2*Cells] = '0;
    end

    // letter count, saturating at k, restarted by a new sequence or a k-mer size write
    assign w_base = w_let.flush ? '0 : r_seen;
    assign n_seen = (w_base < w_k) ? (w_base + rck_pkg::K_W'(1)) : w_base;
    assign w_emit = (n_seen == w_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_kmer_wr) begin
            r_seen <= '0;
        end else if (w_take) begin
            r_seen <= n_seen;
        end
    end

    // compare and select on the shifted words
    assign w_fwd_lt = (w_fwd_nxt < w_rev_nxt);

    always_comb begin
        case (r_mode)
            rck_pkg::MODE_DIRECT:  w_sel = w_fwd_nxt;
            rck_pkg::MODE_REVCOMP: w_sel = w_rev_nxt;
            default:               w_sel = w_fwd_lt ? w_fwd_nxt : w_rev_nxt;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_take && w_emit) begin
            r_ov <= 1'b1;
        end else if (o_kmer.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_kmer <= w_sel;
            r_fs   <= w_fwd_lt;
            r_last <= w_let.last;
        end
    end

    assign o_kmer.valid           = r_ov;
    assign o_kmer.kmer_value      = r_kmer;
    assign o_kmer.forward_smaller = r_fs;
    assign o_kmer.last_of_item    = r_last;

    // checks
    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= w_k)
        else $error("letter count above k");

    a_kmer_wr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_kmer_wr |=> (r_seen == '0))
        else $error("k-mer size write did not restart the sequence");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_emit) |=> r_ov)
        else $error("completed k-mer not presented");

    a_fwd_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fwd_cur >> {w_k, 1'b0}) == '0)
        else $error("forward word has letters beyond k");

endmodule
